// File: rtl/e8q_pkg.sv
// shared constants and helpers for the e8 lattice quantiser
package e8q_pkg;

  localparam int DIM   = 8;
  localparam int IDX_W = 3;
  localparam int OUT_W = 14;

  // the two decoder runs: plain integer lattice and the half-shifted one
  localparam int NUM_COSETS   = 2;
  localparam int COSET_INT    = 0;
  localparam int COSET_HALF   = 1;

endpackage

// File: rtl/e8q_if.sv
// valid/ready channel interfaces for the input vector and the lattice point
interface e8q_in_if #(
  parameter int COORD_WIDTH = 20
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] in_0;
  logic signed [COORD_WIDTH-1:0] in_1;
  logic signed [COORD_WIDTH-1:0] in_2;
  logic signed [COORD_WIDTH-1:0] in_3;
  logic signed [COORD_WIDTH-1:0] in_4;
  logic signed [COORD_WIDTH-1:0] in_5;
  logic signed [COORD_WIDTH-1:0] in_6;
  logic signed [COORD_WIDTH-1:0] in_7;

  modport source (
    output valid, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
    input  ready
  );
  modport sink (
    input  valid, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
    output ready
  );
endinterface

interface e8q_out_if ();
  import e8q_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_0;
  logic signed [OUT_W-1:0] out_1;
  logic signed [OUT_W-1:0] out_2;
  logic signed [OUT_W-1:0] out_3;
  logic signed [OUT_W-1:0] out_4;
  logic signed [OUT_W-1:0] out_5;
  logic signed [OUT_W-1:0] out_6;
  logic signed [OUT_W-1:0] out_7;
  logic                    half_coset;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7, half_coset,
    input  ready
  );
  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7, half_coset,
    output ready
  );
endinterface

// File: rtl/e8q_round_lane.sv
// one coordinate lane: round half away from zero and form the residual
module e8q_round_lane #(
  parameter int A_W = 22,
  parameter int Y_W = 13,
  parameter int R_W = 10,
  parameter int SH  = 9
) (
  input  logic signed [A_W-1:0] a,
  output logic signed [Y_W-1:0] y,
  output logic signed [R_W-1:0] d
);

  localparam logic [A_W-1:0] HALF = A_W'(1) << (SH - 1);

  logic [A_W-1:0]        mag;
  logic [A_W-1:0]        rnd;
  logic signed [A_W:0]   y_scaled;
  logic signed [A_W:0]   diff;

  always_comb begin
    mag      = a[A_W-1] ? A_W'(-a) : A_W'(a);
    rnd      = (mag + HALF) >> SH;
    y        = a[A_W-1] ? -Y_W'(rnd) : Y_W'(rnd);
    y_scaled = (A_W + 1)'(y) <<< SH;
    diff     = (A_W + 1)'(a) - y_scaled;
    d        = R_W'(diff);
  end

endmodule

// File: rtl/e8q_parity_fix.sv
// merge across lanes: on odd sum, step the worst-rounded coordinate toward its input
module e8q_parity_fix #(
  parameter int Y_W = 13,
  parameter int R_W = 10,
  parameter int E_W = 11,
  parameter int SH  = 9
) (
  input  logic signed [Y_W-1:0] y   [e8q_pkg::DIM],
  input  logic signed [R_W-1:0] d   [e8q_pkg::DIM],
  output logic signed [Y_W-1:0] yf  [e8q_pkg::DIM],
  output logic signed [E_W-1:0] e   [e8q_pkg::DIM]
);
  import e8q_pkg::*;

  localparam logic signed [E_W-1:0] ONE = E_W'(1) << SH;

  logic [R_W-2:0]   mag [DIM];
  logic [R_W-2:0]   best_mag;
  logic [IDX_W-1:0] best;
  logic             odd;
  logic             up;

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      mag[i] = d[i][R_W-1] ? (R_W-1)'(-d[i]) : (R_W-1)'(d[i]);
    end
    odd = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      odd = odd ^ y[i][0];
    end
    // strictly larger error takes over, so the lowest index keeps a tie
    best     = '0;
    best_mag = mag[0];
    for (int i = 1; i < DIM; i++) begin
      if (mag[i] > best_mag) begin
        best_mag = mag[i];
        best     = IDX_W'(i);
      end
    end
    up = !d[best][R_W-1];
    for (int i = 0; i < DIM; i++) begin
      if (odd && best == IDX_W'(i)) begin
        yf[i] = up ? y[i] + Y_W'(1) : y[i] - Y_W'(1);
        e[i]  = up ? E_W'(d[i]) - ONE : E_W'(d[i]) + ONE;
      end else begin
        yf[i] = y[i];
        e[i]  = E_W'(d[i]);
      end
    end
  end

endmodule

// File: rtl/e8_lattice_quantizer.sv
// e8 lattice nearest-point quantiser, top level and pipeline
//
// sample channel carries one 8-element vector per item, each coordinate in
// two's complement with FRAC_BITS fraction bits. point channel returns the
// nearest e8 lattice point as doubled integer coordinates plus a flag that
// marks the half-integer coset.
// sixteen rounding lanes (eight coordinates, two cosets) feed a parity
// merge per coset, then sixteen squaring lanes, a distance sum per coset
// and a final compare/select; equal distances keep the integer point.
// each item passes through stage registers s1, s2, s3, s4 and the output.
// throughput: one item per cycle unless point stalls; one item per stage.
// ready on sample falls only when all five stage registers are full and
// point is stalled, so a stalled receiver backs up the pipeline one stage
// at a time while earlier bubbles are still filled.
// reset empties every stage; no item is held or lost across it beyond that.
module e8_lattice_quantizer #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 8
) (
  input  logic      clk,
  input  logic      rst,
  e8q_in_if.sink    sample,
  e8q_out_if.source point
);
  import e8q_pkg::*;

  localparam int SH   = FRAC_BITS + 1;
  localparam int A_W  = ((COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS + 1) + 2;
  localparam int Y_W  = (COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH - FRAC_BITS + 1 : 4;
  localparam int R_W  = FRAC_BITS + 2;
  localparam int E_W  = FRAC_BITS + 3;
  localparam int SQ_W = 2 * FRAC_BITS + 4;
  localparam int D_W  = SQ_W + IDX_W;

  localparam logic signed [A_W-1:0] HALF_A = A_W'(1) << FRAC_BITS;

  // stage valids and advance enables
  logic v1, v2, v3, v4, vo;
  logic en1, en2, en3, en4, eno;

  logic signed [COORD_WIDTH-1:0] coord [DIM];
  logic signed [A_W-1:0]  a_in  [NUM_COSETS][DIM];
  logic signed [Y_W-1:0]  r_y   [NUM_COSETS][DIM];
  logic signed [R_W-1:0]  r_d   [NUM_COSETS][DIM];

  logic signed [Y_W-1:0]  s1_y  [NUM_COSETS][DIM];
  logic signed [R_W-1:0]  s1_d  [NUM_COSETS][DIM];

  logic signed [Y_W-1:0]  f_y   [NUM_COSETS][DIM];
  logic signed [E_W-1:0]  f_e   [NUM_COSETS][DIM];

  logic signed [Y_W-1:0]  s2_y  [NUM_COSETS][DIM];
  logic signed [E_W-1:0]  s2_e  [NUM_COSETS][DIM];

  logic [SQ_W-1:0]        sq_next [NUM_COSETS][DIM];
  logic signed [Y_W-1:0]  s3_y  [NUM_COSETS][DIM];
  logic [SQ_W-1:0]        s3_sq [NUM_COSETS][DIM];

  logic [D_W-1:0]         dist_next [NUM_COSETS];
  logic signed [Y_W-1:0]  s4_y  [NUM_COSETS][DIM];
  logic [D_W-1:0]         s4_dist [NUM_COSETS];

  logic                   pick_half;
  logic signed [Y_W:0]    dbl [DIM];
  logic signed [OUT_W-1:0] out_q [DIM];
  logic                   half_q;

  logic                   s2_odd [NUM_COSETS];
  logic signed [2*E_W-1:0] prod [NUM_COSETS][DIM];

  assign eno = !vo || point.ready;
  assign en4 = !v4 || eno;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign sample.ready = en1;

  always_comb begin
    coord[0] = COORD_WIDTH'(sample.in_0);
    coord[1] = COORD_WIDTH'(sample.in_1);
    coord[2] = COORD_WIDTH'(sample.in_2);
    coord[3] = COORD_WIDTH'(sample.in_3);
    coord[4] = COORD_WIDTH'(sample.in_4);
    coord[5] = COORD_WIDTH'(sample.in_5);
    coord[6] = COORD_WIDTH'(sample.in_6);
    coord[7] = COORD_WIDTH'(sample.in_7);
    for (int i = 0; i < DIM; i++) begin
      // one extra fraction bit so that one half is a whole step
      a_in[COSET_INT][i]  = A_W'(coord[i]) <<< 1;
      a_in[COSET_HALF][i] = (A_W'(coord[i]) <<< 1) - HALF_A;
    end
  end

  for (genvar c = 0; c < NUM_COSETS; c++) begin : g_coset
    for (genvar i = 0; i < DIM; i++) begin : g_lane
      e8q_round_lane #(
        .A_W (A_W),
        .Y_W (Y_W),
        .R_W (R_W),
        .SH  (SH)
      ) u_round (
        .a (a_in[c][i]),
        .y (r_y[c][i]),
        .d (r_d[c][i])
      );
    end

    e8q_parity_fix #(
      .Y_W (Y_W),
      .R_W (R_W),
      .E_W (E_W),
      .SH  (SH)
    ) u_fix (
      .y  (s1_y[c]),
      .d  (s1_d[c]),
      .yf (f_y[c]),
      .e  (f_e[c])
    );
  end

  always_comb begin
    for (int c = 0; c < NUM_COSETS; c++) begin
      s2_odd[c] = 1'b0;
      for (int i = 0; i < DIM; i++) begin
        prod[c][i]    = s2_e[c][i] * s2_e[c][i];
        sq_next[c][i] = prod[c][i][SQ_W-1:0];
        s2_odd[c]     = s2_odd[c] ^ s2_y[c][i][0];
      end
    end
    for (int c = 0; c < NUM_COSETS; c++) begin
      dist_next[c] = '0;
      for (int i = 0; i < DIM; i++) begin
        dist_next[c] = dist_next[c] + D_W'(s3_sq[c][i]);
      end
    end
    // integer point keeps a tie
    pick_half = s4_dist[COSET_HALF] < s4_dist[COSET_INT];
    for (int i = 0; i < DIM; i++) begin
      dbl[i] = pick_half ? {s4_y[COSET_HALF][i], 1'b1} : {s4_y[COSET_INT][i], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (en1) v1 <= sample.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (eno) vo <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_y <= r_y;
      s1_d <= r_d;
    end
    if (en2) begin
      s2_y <= f_y;
      s2_e <= f_e;
    end
    if (en3) begin
      s3_y  <= s2_y;
      s3_sq <= sq_next;
    end
    if (en4) begin
      s4_y    <= s3_y;
      s4_dist <= dist_next;
    end
    if (eno) begin
      for (int i = 0; i < DIM; i++) begin
        out_q[i] <= OUT_W'(dbl[i]);
      end
      half_q <= pick_half;
    end
  end

  assign point.valid      = vo;
  assign point.out_0      = out_q[0];
  assign point.out_1      = out_q[1];
  assign point.out_2      = out_q[2];
  assign point.out_3      = out_q[3];
  assign point.out_4      = out_q[4];
  assign point.out_5      = out_q[5];
  assign point.out_6      = out_q[6];
  assign point.out_7      = out_q[7];
  assign point.half_coset = half_q;

  // after the merge both candidates lie in d8
  a_even_sum: assert property (@(posedge clk) disable iff (rst)
    v2 |-> !s2_odd[COSET_INT] && !s2_odd[COSET_HALF])
    else $error("candidate with odd coordinate sum after parity merge");

  // half coset means every doubled coordinate is odd
  a_half_odd: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.half_coset |->
      point.out_0[0] && point.out_1[0] && point.out_2[0] && point.out_3[0] &&
      point.out_4[0] && point.out_5[0] && point.out_6[0] && point.out_7[0])
    else $error("half coset point with an even coordinate");

  a_int_even: assert property (@(posedge clk) disable iff (rst)
    point.valid && !point.half_coset |->
      !point.out_0[0] && !point.out_1[0] && !point.out_2[0] && !point.out_3[0] &&
      !point.out_4[0] && !point.out_5[0] && !point.out_6[0] && !point.out_7[0])
    else $error("integer point with an odd coordinate");

  // back-pressure only when the whole pipeline is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> v1 && v2 && v3 && v4 && vo && !point.ready)
    else $error("sample stalled while a stage was free");

  a_take: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> v1)
    else $error("accepted item missing from first stage");

endmodule

// File: test/e8_point_checker.sv
// scoreboard for the e8 quantiser: predicts the nearest lattice point per item and compares
`timescale 1ns / 1ps
module e8_point_checker #(
  parameter int COORD_WIDTH = 20,
  parameter int FRAC_BITS   = 8
) (
  input  logic clk,
  input  logic rst,
  e8q_in_if    sample,
  e8q_out_if   point,
  output int   fails,
  output int   outstanding
);
  import e8q_pkg::*;

  // internal scale has one extra fraction bit so that one half is a whole step
  localparam longint UNIT_STEP = longint'(1) << (FRAC_BITS + 1);
  localparam longint HALF_STEP = longint'(1) << FRAC_BITS;

  typedef longint coord_vec_t [DIM];
  typedef struct packed {
    logic                      half;
    logic [DIM-1:0][OUT_W-1:0] coord;
  } lattice_point_t;

  lattice_point_t expected_points[$];
  int mismatches = 0;
  int pending    = 0;

  assign fails       = mismatches;
  assign outstanding = pending;

  function automatic longint widen_coord(logic signed [COORD_WIDTH-1:0] c);
    return longint'(c);
  endfunction

  // nearest d8 point in whole units, input in the doubled scale
  function automatic coord_vec_t round_to_d8(coord_vec_t a);
    coord_vec_t y;
    longint     mag;
    longint     err;
    longint     worst_err;
    int         worst;
    logic       odd;
    odd = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      mag  = (a[i] < 0) ? -a[i] : a[i];
      y[i] = (mag + HALF_STEP) >> (FRAC_BITS + 1);
      if (a[i] < 0) y[i] = -y[i];
      odd ^= y[i][0];
    end
    if (odd) begin
      // move the worst-rounded coordinate back toward its input, lowest index on a tie
      worst     = 0;
      worst_err = -1;
      for (int i = 0; i < DIM; i++) begin
        err = a[i] - y[i] * UNIT_STEP;
        if (err < 0) err = -err;
        if (err > worst_err) begin
          worst_err = err;
          worst     = i;
        end
      end
      err = a[worst] - y[worst] * UNIT_STEP;
      y[worst] += (err >= 0) ? 1 : -1;
    end
    return y;
  endfunction

  function automatic lattice_point_t nearest_e8(coord_vec_t raw);
    coord_vec_t     x;
    coord_vec_t     xs;
    coord_vec_t     y_int;
    coord_vec_t     y_half;
    longint         e_int;
    longint         e_half;
    longint         dist_int;
    longint         dist_half;
    lattice_point_t p;
    for (int i = 0; i < DIM; i++) begin
      x[i]  = raw[i] * 2;
      xs[i] = x[i] - HALF_STEP;
    end
    y_int  = round_to_d8(x);
    y_half = round_to_d8(xs);
    dist_int  = 0;
    dist_half = 0;
    for (int i = 0; i < DIM; i++) begin
      e_int     = x[i] - y_int[i] * UNIT_STEP;
      e_half    = x[i] - (2 * y_half[i] + 1) * HALF_STEP;
      dist_int  += e_int * e_int;
      dist_half += e_half * e_half;
    end
    // equal distances keep the integer point
    p.half = (dist_half < dist_int);
    for (int i = 0; i < DIM; i++)
      p.coord[i] = p.half ? OUT_W'(2 * y_half[i] + 1) : OUT_W'(2 * y_int[i]);
    return p;
  endfunction

  always @(posedge clk) begin
    coord_vec_t     vec;
    lattice_point_t want;
    lattice_point_t got;
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        vec[0] = widen_coord(sample.in_0);
        vec[1] = widen_coord(sample.in_1);
        vec[2] = widen_coord(sample.in_2);
        vec[3] = widen_coord(sample.in_3);
        vec[4] = widen_coord(sample.in_4);
        vec[5] = widen_coord(sample.in_5);
        vec[6] = widen_coord(sample.in_6);
        vec[7] = widen_coord(sample.in_7);
        expected_points.insert(expected_points.size(), nearest_e8(vec));
      end
      if (point.valid && point.ready) begin
        got = {point.half_coset, point.out_7, point.out_6, point.out_5, point.out_4,
               point.out_3, point.out_2, point.out_1, point.out_0};
        if (expected_points.size() == 0) begin
          $error("point item with no vector pending");
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (want.half != got.half) begin
            $error("half_coset: expected %0d, got %0d", want.half, got.half);
            mismatches++;
          end
          for (int i = 0; i < DIM; i++) begin
            if (want.coord[i] != got.coord[i]) begin
              $error("out_%0d: expected %0d, got %0d", i,
                     $signed(want.coord[i]), $signed(got.coord[i]));
              mismatches++;
            end
          end
        end
      end
    end
    pending <= expected_points.size();
  end

endmodule

// File: test/testbench.sv
// top of the e8 quantiser testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import e8q_pkg::*;

  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 8;
  localparam int UNIT        = 1 << FRAC_BITS;
  localparam int PHASE_ITEMS = 450;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t vector_t [DIM];

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   send_idle = 6;
  int   recv_idle = 57;
  int   fails;
  int   outstanding;

  e8q_in_if #(.COORD_WIDTH(COORD_WIDTH)) sample ();
  e8q_out_if point ();

  e8_lattice_quantizer #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .sample(sample),
    .point (point)
  );

  e8_point_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .point      (point),
    .fails      (fails),
    .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    point.ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #2_000_000;
    $display("[e8_lattice_quantizer] ERROR");
    $finish;
  end

  task automatic send_vector(input vector_t v);
    while ($urandom_range(99) < send_idle) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.in_0  <= v[0];
    sample.in_1  <= v[1];
    sample.in_2  <= v[2];
    sample.in_3  <= v[3];
    sample.in_4  <= v[4];
    sample.in_5  <= v[5];
    sample.in_6  <= v[6];
    sample.in_7  <= v[7];
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
  endtask

  task automatic drain_points();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic vector_t uniform(coord_t c);
    vector_t v;
    foreach (v[i]) v[i] = c;
    return v;
  endfunction

  // wide noise, small values, quarter grid (rounding ties) or close to half-grid points
  function automatic coord_t random_coord(int mode);
    case (mode)
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(0, 16 * UNIT)) - 8 * UNIT);
      2:       return coord_t'((int'($urandom_range(0, 32)) - 16) * (UNIT / 4));
      default: return coord_t'((int'($urandom_range(0, 16)) - 8) * (UNIT / 2)
                               + int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  function automatic vector_t random_vector();
    vector_t v;
    int      mode;
    mode = $urandom_range(0, 4);
    foreach (v[i]) v[i] = random_coord((mode == 4) ? $urandom_range(0, 3) : mode);
    return v;
  endfunction

  initial begin
    sample.valid <= 1'b0;
    sample.in_0  <= '0;
    sample.in_1  <= '0;
    sample.in_2  <= '0;
    sample.in_3  <= '0;
    sample.in_4  <= '0;
    sample.in_5  <= '0;
    sample.in_6  <= '0;
    sample.in_7  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_vector(uniform('0));
    send_vector(uniform(coord_t'(UNIT / 2)));
    send_vector(uniform(coord_t'(-UNIT / 2)));
    // integer and half candidates equally far: integer wins
    send_vector(uniform(coord_t'(UNIT / 4)));
    send_vector(uniform(coord_t'(-UNIT / 4)));
    send_vector(uniform(coord_t'(524287)));
    send_vector(uniform(coord_t'(-524288)));
    send_vector('{524287, -524288, 524287, -524288, 524287, -524288, 524287, -524288});
    send_vector('{524287, 0, 0, 0, 0, 0, 0, 0});
    send_vector('{0, 0, 0, 0, 0, 0, 0, -524288});
    // odd sum with no rounding error: first coordinate steps up
    send_vector('{coord_t'(UNIT), 0, 0, 0, 0, 0, 0, 0});
    send_vector('{coord_t'(-UNIT), 0, 0, 0, 0, 0, 0, 0});
    send_vector('{0, 0, 0, 0, 0, 0, 0, coord_t'(3 * UNIT)});
    // same on the half-shifted decoder
    send_vector('{coord_t'(3 * UNIT / 2), coord_t'(UNIT / 2), coord_t'(UNIT / 2),
                  coord_t'(UNIT / 2), coord_t'(UNIT / 2), coord_t'(UNIT / 2),
                  coord_t'(UNIT / 2), coord_t'(UNIT / 2)});
    // equal worst errors: lowest index moves
    send_vector('{coord_t'(UNIT / 4), coord_t'(UNIT / 4), 0, 0, 0, 0, 0, coord_t'(UNIT)});
    send_vector('{coord_t'(-UNIT / 4), coord_t'(UNIT / 4), coord_t'(-UNIT / 4),
                  0, 0, 0, 0, coord_t'(-UNIT)});
    send_vector('{coord_t'(-3 * UNIT / 2), coord_t'(UNIT / 2), coord_t'(-UNIT / 2),
                  coord_t'(5 * UNIT / 2), coord_t'(-5 * UNIT / 2), coord_t'(7 * UNIT / 2),
                  0, coord_t'(UNIT)});
    send_vector('{127, -127, 129, -129, 383, -383, 1, -1});
    send_vector(uniform(coord_t'(20'h55555)));
    send_vector(uniform(coord_t'(20'haaaaa)));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 6;
          recv_idle = 57;
        end
        1: begin
          send_idle = 57;
          recv_idle = 6;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_vector(random_vector());
      // hold off until the pipeline has emptied
      drain_points();
    end

    repeat (12) @(posedge clk);
    if (fails == 0) begin
      $display("[e8_lattice_quantizer] OK");
    end else begin
      $display("[e8_lattice_quantizer] ERROR");
    end
    $finish;
  end

endmodule

// File: e8_lattice_quantizer.f
rtl/e8q_pkg.sv
rtl/e8q_if.sv
rtl/e8q_round_lane.sv
rtl/e8q_parity_fix.sv
rtl/e8_lattice_quantizer.sv
test/e8_point_checker.sv
test/testbench.sv
